FILE: src/cna_pkg.sv
// ----------------------------------------------------------------------------
// Complex number ALU package
// Shared widths, operation and status codes, and the record that travels
// through the divider pipeline.
// ----------------------------------------------------------------------------
package cna_pkg;

   localparam int IN_W      = 16;
   localparam int FRAC_BITS = 8;
   localparam int OUT_FRAC  = 2 * FRAC_BITS;
   localparam int OUT_W     = 32;
   localparam int PROD_W    = 2 * IN_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int ADD_W     = IN_W + 1;
   localparam int DEN_W     = PROD_W;
   localparam int MAG_W     = PROD_W;
   localparam int NUM_W     = MAG_W + OUT_FRAC;
   localparam int Q_W       = OUT_W + 1;
   localparam int TRIAL_W   = DEN_W + Q_W - 1;
   localparam int LIM_W     = DEN_W + OUT_W;

   typedef enum logic [2:0] {
      FUNC_MUL = 3'd0,
      FUNC_ADD = 3'd1,
      FUNC_SUB = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_CMP = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_DIVZ   = 2'd1,
      STAT_SAT    = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]       func;
      logic [OUT_W-1:0] pre_re;
      logic [OUT_W-1:0] pre_im;
      logic             pre_ovf;
      logic             same;
      logic             zero;
      logic             neg_re;
      logic             neg_im;
      logic             ovf_re;
      logic             ovf_im;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [DEN_W-1:0] den;
      logic [NUM_W-1:0] rem_re;
      logic [NUM_W-1:0] rem_im;
      logic [Q_W-1:0]   q_re;
      logic [Q_W-1:0]   q_im;
   } div_item_type;

endpackage

FILE: src/complex_number_alu.sv
// ----------------------------------------------------------------------------
// Complex number ALU
// Multiply, add, subtract, divide and compare of two Q8.8 complex operands,
// with a saturated Q16.16 complex result and a status code.
// ----------------------------------------------------------------------------
// Channel | Ports                                   | Direction
// req     | req_valid req_stall req_func req_x_* y_* | in
// rsp     | rsp_valid rsp_stall rsp_res_* same status | out
//
// One transfer per clock is accepted in steady state while the result side does not stall.
// A request passes three front stages, one stage per quotient bit of
// the shared restoring divider, and the output register.
// Every stage has its own valid bit, so empty stages keep moving while the
// output waits. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module complex_number_alu
   import cna_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_func,
   input  logic signed [IN_W-1:0]  req_x_re,
   input  logic signed [IN_W-1:0]  req_x_im,
   input  logic signed [IN_W-1:0]  req_y_re,
   input  logic signed [IN_W-1:0]  req_y_im,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_res_re,
   output logic signed [OUT_W-1:0] rsp_res_im,
   output logic                    rsp_same,
   output logic [1:0]              rsp_status
);

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic e1, e2, e3, eo;

   logic [2:0] f1_ff, f2_ff;
   logic signed [PROD_W-1:0] ac_ff, bd_ff, ad_ff, bc_ff, cc_ff, dd_ff;
   logic signed [ADD_W-1:0] sr_ff, si_ff, sr2_ff, si2_ff, sr_in, si_in;
   logic same1_ff, same2_ff;

   logic signed [SUM_W-1:0] mre_ff, mim_ff, dre_ff, dim_ff;
   logic [DEN_W-1:0] den_ff;

   div_item_type it3_in, it3_ff, div_out;
   logic div_in_stall, div_out_valid;

   logic signed [OUT_W-1:0] re_in, im_in, re_ff, im_ff;
   logic same_in, same_ff;
   logic [1:0] st_in, st_ff;

   assign eo = !vo_ff || !rsp_stall;
   assign e3 = !v3_ff || !div_in_stall;
   assign e2 = !v2_ff || e3;
   assign e1 = !v1_ff || e2;
   assign req_stall = !e1;

   always_comb begin
      if (req_func == FUNC_SUB) begin
         sr_in = ADD_W'(req_x_re) - ADD_W'(req_y_re);
         si_in = ADD_W'(req_x_im) - ADD_W'(req_y_im);
      end else begin
         sr_in = ADD_W'(req_x_re) + ADD_W'(req_y_re);
         si_in = ADD_W'(req_x_im) + ADD_W'(req_y_im);
      end
   end

   always_ff @(posedge clock) begin
      if (e1) begin
         f1_ff    <= req_func;
         ac_ff    <= req_x_re * req_y_re;
         bd_ff    <= req_x_im * req_y_im;
         ad_ff    <= req_x_re * req_y_im;
         bc_ff    <= req_x_im * req_y_re;
         cc_ff    <= req_y_re * req_y_re;
         dd_ff    <= req_y_im * req_y_im;
         sr_ff    <= sr_in;
         si_ff    <= si_in;
         same1_ff <= (req_x_re == req_y_re) && (req_x_im == req_y_im);
      end
      if (e2) begin
         f2_ff    <= f1_ff;
         mre_ff   <= SUM_W'(ac_ff) - SUM_W'(bd_ff);
         mim_ff   <= SUM_W'(ad_ff) + SUM_W'(bc_ff);
         dre_ff   <= SUM_W'(ac_ff) + SUM_W'(bd_ff);
         dim_ff   <= SUM_W'(bc_ff) - SUM_W'(ad_ff);
         den_ff   <= $unsigned(cc_ff) + $unsigned(dd_ff);
         sr2_ff   <= sr_ff;
         si2_ff   <= si_ff;
         same2_ff <= same1_ff;
      end
      if (e3) begin
         it3_ff <= it3_in;
      end
      if (eo) begin
         re_ff   <= re_in;
         im_ff   <= im_in;
         same_ff <= same_in;
         st_ff   <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (e1) begin
            v1_ff <= req_valid;
         end
         if (e2) begin
            v2_ff <= v1_ff;
         end
         if (e3) begin
            v3_ff <= v2_ff;
         end
         if (eo) begin
            vo_ff <= div_out_valid;
         end
      end
   end

   always_comb begin
      logic [MAG_W-1:0] mag_re, mag_im;
      logic [NUM_W-1:0] n_re, n_im;
      logic [LIM_W-1:0] lim_re, lim_im;
      mag_re = dre_ff[SUM_W-1] ? MAG_W'(-dre_ff) : MAG_W'(dre_ff);
      mag_im = dim_ff[SUM_W-1] ? MAG_W'(-dim_ff) : MAG_W'(dim_ff);
      n_re = NUM_W'(mag_re) << OUT_FRAC;
      n_im = NUM_W'(mag_im) << OUT_FRAC;
      lim_re = (LIM_W'(den_ff) << (OUT_W - 1)) + (dre_ff[SUM_W-1] ? LIM_W'(den_ff) : '0);
      lim_im = (LIM_W'(den_ff) << (OUT_W - 1)) + (dim_ff[SUM_W-1] ? LIM_W'(den_ff) : '0);

      it3_in = '0;
      it3_in.side.func   = f2_ff;
      it3_in.side.zero   = (den_ff == '0);
      it3_in.side.neg_re = dre_ff[SUM_W-1];
      it3_in.side.neg_im = dim_ff[SUM_W-1];
      it3_in.side.ovf_re = LIM_W'(n_re) >= lim_re;
      it3_in.side.ovf_im = LIM_W'(n_im) >= lim_im;
      it3_in.den    = den_ff;
      it3_in.rem_re = n_re;
      it3_in.rem_im = n_im;

      case (f2_ff)
         FUNC_MUL: begin
            it3_in.side.pre_re = (mre_ff[SUM_W-1] != mre_ff[SUM_W-2])
               ? {mre_ff[SUM_W-1], {(OUT_W-1){!mre_ff[SUM_W-1]}}} : mre_ff[OUT_W-1:0];
            it3_in.side.pre_im = (mim_ff[SUM_W-1] != mim_ff[SUM_W-2])
               ? {mim_ff[SUM_W-1], {(OUT_W-1){!mim_ff[SUM_W-1]}}} : mim_ff[OUT_W-1:0];
            it3_in.side.pre_ovf = (mre_ff[SUM_W-1] != mre_ff[SUM_W-2])
               || (mim_ff[SUM_W-1] != mim_ff[SUM_W-2]);
         end
         FUNC_ADD, FUNC_SUB: begin
            it3_in.side.pre_re = OUT_W'($signed({sr2_ff, {FRAC_BITS{1'b0}}}));
            it3_in.side.pre_im = OUT_W'($signed({si2_ff, {FRAC_BITS{1'b0}}}));
         end
         FUNC_CMP: begin
            it3_in.side.same = same2_ff;
         end
         default: begin
         end
      endcase
   end

   cna_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_item   (it3_ff),
      .in_stall  (div_in_stall),
      .out_valid (div_out_valid),
      .out_item  (div_out),
      .out_stall (!eo)
   );

   always_comb begin
      logic [Q_W-1:0] nq_re, nq_im;
      nq_re = div_out.side.neg_re ? -div_out.q_re : div_out.q_re;
      nq_im = div_out.side.neg_im ? -div_out.q_im : div_out.q_im;
      re_in   = div_out.side.pre_re;
      im_in   = div_out.side.pre_im;
      same_in = div_out.side.same;
      st_in   = div_out.side.pre_ovf ? STAT_SAT : STAT_OK;
      if (div_out.side.func == FUNC_DIV) begin
         if (div_out.side.zero) begin
            re_in = '0;
            im_in = '0;
            st_in = STAT_DIVZ;
         end else begin
            re_in = div_out.side.ovf_re
               ? {div_out.side.neg_re, {(OUT_W-1){!div_out.side.neg_re}}} : nq_re[OUT_W-1:0];
            im_in = div_out.side.ovf_im
               ? {div_out.side.neg_im, {(OUT_W-1){!div_out.side.neg_im}}} : nq_im[OUT_W-1:0];
            st_in = (div_out.side.ovf_re || div_out.side.ovf_im) ? STAT_SAT : STAT_OK;
         end
      end
   end

   assign rsp_valid  = vo_ff;
   assign rsp_res_re = re_ff;
   assign rsp_res_im = im_ff;
   assign rsp_same   = same_ff;
   assign rsp_status = st_ff;

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_DIVZ |-> rsp_res_re == '0 && rsp_res_im == '0)
      else $error("divide by zero result is not zero");

   a_same_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_same |-> rsp_status == STAT_OK && rsp_res_re == '0 && rsp_res_im == '0)
      else $error("compare result carries data or status");

   a_stall_chain: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff)
      else $error("input stalled while a front stage is empty");

endmodule

FILE: src/cna_div_pipe.sv
// ----------------------------------------------------------------------------
// Complex number ALU divider pipeline
// Restoring division of two numerators by one shared divisor, one quotient
// bit per register stage, with per-stage valid bits that close bubbles.
// ----------------------------------------------------------------------------
module cna_div_pipe
   import cna_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  div_item_type in_item,
   output logic         in_stall,
   output logic         out_valid,
   output div_item_type out_item,
   input  logic         out_stall
);

   div_item_type pipe_ff [Q_W];
   div_item_type pipe_in [Q_W];
   logic [Q_W-1:0] vld_ff;
   logic [Q_W:0]   en;

   assign en[Q_W] = !out_stall;

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      localparam int SH = Q_W - 1 - k;
      div_item_type src;
      logic [TRIAL_W-1:0] trial;
      logic take_re;
      logic take_im;

      if (k == 0) begin : g_first
         assign src = in_item;
      end else begin : g_next
         assign src = pipe_ff[k-1];
      end

      always_comb begin
         trial   = TRIAL_W'(src.den) << SH;
         take_re = TRIAL_W'(src.rem_re) >= trial;
         take_im = TRIAL_W'(src.rem_im) >= trial;
         pipe_in[k] = src;
         pipe_in[k].q_re = {src.q_re[Q_W-2:0], take_re};
         pipe_in[k].q_im = {src.q_im[Q_W-2:0], take_im};
         if (take_re) begin
            pipe_in[k].rem_re = src.rem_re - trial[NUM_W-1:0];
         end
         if (take_im) begin
            pipe_in[k].rem_im = src.rem_im - trial[NUM_W-1:0];
         end
      end

      assign en[k] = !vld_ff[k] || en[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en[k]) begin
            vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1 < 0 ? 0 : k-1];
         end
         if (en[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign in_stall  = !en[0];
   assign out_valid = vld_ff[Q_W-1];
   assign out_item  = pipe_ff[Q_W-1];

endmodule

FILE: tb/tb_complex_number_alu.sv
// ----------------------------------------------------------------------------
// Complex number ALU testbench
// Feeds the ALU operand pairs in bursts with random gaps, stalls the result
// side on its own pattern, and compares every result transfer against a
// predicted complex result, equality flag and status, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_number_alu;
   import cna_pkg::*;

   typedef struct {
      logic [2:0]             func;
      logic signed [IN_W-1:0] x_re;
      logic signed [IN_W-1:0] x_im;
      logic signed [IN_W-1:0] y_re;
      logic signed [IN_W-1:0] y_im;
      bit                     drain;
   } operands_type;

   typedef struct {
      logic signed [OUT_W-1:0] re;
      logic signed [OUT_W-1:0] im;
      logic                    same;
      logic [1:0]              status;
   } outcome_type;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_valid = 0;
   logic                    req_stall;
   logic [2:0]              req_func = '0;
   logic signed [IN_W-1:0]  req_x_re = '0;
   logic signed [IN_W-1:0]  req_x_im = '0;
   logic signed [IN_W-1:0]  req_y_re = '0;
   logic signed [IN_W-1:0]  req_y_im = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 0;
   logic signed [OUT_W-1:0] rsp_res_re;
   logic signed [OUT_W-1:0] rsp_res_im;
   logic                    rsp_same;
   logic [1:0]              rsp_status;

   operands_type pending_ops[$];
   outcome_type  expected_outcomes[$];
   int           error_count = 0;
   int           accepted_count = 0;
   int           gap_left = 0;
   int           burst_left = 0;
   int           hold_left = 0;
   bit           hold_done = 0;
   int           stall_mode = 0;
   int           mode_left = 0;

   complex_number_alu dut (.*);

   always #1 clock = ~clock;

   function automatic logic [OUT_W-1:0] clamp32(bit neg, longint unsigned mag, ref bit ovf);
      if (!neg) begin
         if (mag > 64'h7FFF_FFFF) begin
            ovf = 1;
            return 32'h7FFF_FFFF;
         end
         return mag[31:0];
      end
      if (mag > 64'h8000_0000) begin
         ovf = 1;
         return 32'h8000_0000;
      end
      return -mag[31:0];
   endfunction

   function automatic logic [OUT_W-1:0] clamp_signed(longint v, ref bit ovf);
      return clamp32(v < 0, (v < 0) ? -v : v, ovf);
   endfunction

   function automatic logic [OUT_W-1:0] quotient(longint num, longint den, ref bit ovf);
      longint unsigned mag;
      mag = (num < 0) ? -num : num;
      return clamp32(num < 0, (mag << OUT_FRAC) / den, ovf);
   endfunction

   function automatic outcome_type predict_outcome(operands_type op);
      outcome_type r;
      longint a, b, c, d, den;
      bit ovf;
      a = op.x_re; b = op.x_im; c = op.y_re; d = op.y_im;
      ovf = 0;
      r = '{re: '0, im: '0, same: 0, status: STAT_OK};
      case (op.func)
         FUNC_MUL: begin
            r.re = clamp_signed(a * c - b * d, ovf);
            r.im = clamp_signed(a * d + b * c, ovf);
         end
         FUNC_ADD: begin
            r.re = clamp_signed((a + c) <<< FRAC_BITS, ovf);
            r.im = clamp_signed((b + d) <<< FRAC_BITS, ovf);
         end
         FUNC_SUB: begin
            r.re = clamp_signed((a - c) <<< FRAC_BITS, ovf);
            r.im = clamp_signed((b - d) <<< FRAC_BITS, ovf);
         end
         FUNC_DIV: begin
            den = c * c + d * d;
            if (den == 0) r.status = STAT_DIVZ;
            else begin
               r.re = quotient(a * c + b * d, den, ovf);
               r.im = quotient(b * c - a * d, den, ovf);
            end
         end
         FUNC_CMP: r.same = (a == c) && (b == d);
         default: ;
      endcase
      if (ovf) r.status = STAT_SAT;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic add_op(logic [2:0] f, logic [15:0] a, logic [15:0] b,
                         logic [15:0] c, logic [15:0] d, bit drain = 0);
      pending_ops.push_back('{f, a, b, c, d, drain});
   endtask

   function automatic logic [15:0] rnd_part(int kind);
      case (kind)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 15)) - 16'd8;
         2: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 1023)) - 16'd512;
      endcase
   endfunction

   always @(posedge clock) begin
      operands_type op;
      bit           next_valid;
      if (reset) begin
         req_valid <= 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            expected_outcomes.push_back(predict_outcome(pending_ops.pop_front()));
            accepted_count++;
            next_valid = 0;
            if (burst_left > 0) burst_left--;
            else gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
         end
         if (!next_valid) begin
            if (gap_left > 0) gap_left--;
            else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain && expected_outcomes.size() > 0)) begin
               op = pending_ops[0];
               next_valid = 1;
               if (burst_left == 0) burst_left = $urandom_range(0, 40);
               req_func <= op.func;
               req_x_re <= op.x_re;
               req_x_im <= op.x_im;
               req_y_re <= op.y_re;
               req_y_im <= op.y_im;
            end
         end
         req_valid <= next_valid;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (!hold_done && accepted_count >= 300) begin
         hold_done <= 1;
         hold_left <= 150;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end else mode_left--;
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= $urandom_range(0, 1);
         endcase
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result transfer", 1, 0);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_res_re !== want.re) report_mismatch("res_re", rsp_res_re, want.re);
            if (rsp_res_im !== want.im) report_mismatch("res_im", rsp_res_im, want.im);
            if (rsp_same !== want.same) report_mismatch("same", rsp_same, want.same);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   initial begin
      int kind;
      logic [15:0] a, b, c, d;
      add_op(FUNC_MUL, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
      add_op(FUNC_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_op(FUNC_MUL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
      add_op(FUNC_MUL, 16'h0100, 16'h0000, 16'hFF00, 16'h0100);
      add_op(FUNC_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      add_op(FUNC_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_op(FUNC_SUB, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      add_op(FUNC_SUB, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
      add_op(FUNC_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000);
      add_op(FUNC_DIV, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000);
      add_op(FUNC_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF);
      add_op(FUNC_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
      add_op(FUNC_DIV, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000);
      add_op(FUNC_DIV, 16'hFF00, 16'h0300, 16'h0200, 16'hFD00);
      add_op(FUNC_CMP, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      add_op(FUNC_CMP, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFE);
      add_op(FUNC_CMP, 16'h1111, 16'h2222, 16'h1110, 16'h2222);
      add_op(3'd5, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
      add_op(3'd6, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001);
      add_op(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 1400; i++) begin
         kind = $urandom_range(0, 3);
         a = rnd_part(kind); b = rnd_part(kind);
         c = rnd_part($urandom_range(0, 3)); d = rnd_part($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) begin c = a; d = b; end
         if ($urandom_range(0, 19) == 0) begin c = '0; d = '0; end
         add_op($urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4)),
                a, b, c, d, i == 700);
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      wait (pending_ops.size() == 0 && !req_valid && expected_outcomes.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_outcomes.size() == 0)
         $display("** complex_number_alu: PASSED **");
      else
         $display("** complex_number_alu: FAILED **");
      $finish;
   end

   initial begin
      #1ms;
      $display("** complex_number_alu: FAILED **");
      $finish;
   end

endmodule

FILE: complex_number_alu.f
src/cna_pkg.sv
src/cna_div_pipe.sv
src/complex_number_alu.sv
tb/tb_complex_number_alu.sv
